// ===== src/lfss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfss_pkg;

	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned MOVE_W  = 12;
	localparam int unsigned DUR_W   = 16;
	localparam int unsigned PULSE_W = 11;
	localparam int unsigned SPEED_W = 8;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd512;
	localparam logic [SPEED_W-1:0] SPEED_LIMIT     = 8'd200;

	// Register index as decoded from paddr[2].
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_MAX_SPEED = 1'b1;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_MOVE   = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_STOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		EV_NONE       = 2'd0,
		EV_TRACK_LOST = 2'd1,
		EV_CROSSING   = 2'd2
	} event_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] qti_threshold;
		logic [SPEED_W-1:0] max_speed;
	} cfg_t;

	typedef struct packed {
		cmd_t               command;
		logic [LEVEL_W-1:0] left_level;
		logic [LEVEL_W-1:0] middle_level;
		logic [LEVEL_W-1:0] right_level;
		logic [MOVE_W-1:0]  move_left_pulse;
		logic [MOVE_W-1:0]  move_right_pulse;
		logic [DUR_W-1:0]   duration_ms;
	} item_t;

	typedef struct packed {
		logic [PULSE_W-1:0] left_pulse;
		logic [PULSE_W-1:0] right_pulse;
		event_t             event_code;
		logic               move_busy;
		logic               intersection_seen;
	} res_t;

endpackage

`default_nettype wire

// ===== src/lfss_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfss_cfg #(
	parameter int unsigned DEFAULT_SPEED = 100
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output lfss_pkg::cfg_t     cfg
);
	import lfss_pkg::*;

	logic               wr_en;
	logic [SPEED_W-1:0] speed_wr;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && pready;
	assign speed_wr = (pwdata[SPEED_W-1:0] > SPEED_LIMIT) ?
		SPEED_W'(DEFAULT_SPEED) : pwdata[SPEED_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.qti_threshold <= THRESHOLD_RESET;
			cfg.max_speed     <= SPEED_W'(DEFAULT_SPEED);
		end else if (wr_en) begin
			case (paddr[2])
				REG_THRESHOLD: cfg.qti_threshold <= pwdata[LEVEL_W-1:0];
				REG_MAX_SPEED: cfg.max_speed     <= speed_wr;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_THRESHOLD: prdata = {{(32-LEVEL_W){1'b0}}, cfg.qti_threshold};
			REG_MAX_SPEED: prdata = {{(32-SPEED_W){1'b0}}, cfg.max_speed};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/lfss_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfss_core #(
	parameter int unsigned STANDSTILL_US = 1500
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire lfss_pkg::item_t item,
	input  wire lfss_pkg::cfg_t  cfg,
	output logic                res_valid,
	output lfss_pkg::res_t      res
);
	import lfss_pkg::*;

	logic              timed_active_q, timed_active_d;
	logic [DUR_W-1:0]  remaining_ms_q, remaining_ms_d;
	logic [MOVE_W-1:0] held_left_q, held_left_d;
	logic [MOVE_W-1:0] held_right_q, held_right_d;
	logic              off_track_q, off_track_d;
	logic              seen_q, seen_d;

	logic [MOVE_W-1:0] stand;
	logic [MOVE_W-1:0] speed;
	logic [MOVE_W-1:0] half;
	logic [MOVE_W-1:0] lo;
	logic [MOVE_W-1:0] hi;
	logic [MOVE_W-1:0] lp;
	logic [MOVE_W-1:0] rp;
	logic [DUR_W-1:0]  rem_dec;
	logic              l_blk, c_blk, r_blk;
	event_t            ev;

	function automatic logic [PULSE_W-1:0] clamp(
		input logic [MOVE_W-1:0] p,
		input logic [MOVE_W-1:0] lo_v,
		input logic [MOVE_W-1:0] hi_v
	);
		logic [MOVE_W-1:0] t;
		t = p;
		if (t < lo_v) t = lo_v;
		if (t > hi_v) t = hi_v;
		return t[PULSE_W-1:0];
	endfunction

	assign stand = MOVE_W'(STANDSTILL_US);
	assign speed = {{(MOVE_W-SPEED_W){1'b0}}, cfg.max_speed};
	assign half  = speed >> 1;
	assign lo    = stand - speed;
	assign hi    = stand + speed;
	assign l_blk = item.left_level > cfg.qti_threshold;
	assign c_blk = item.middle_level > cfg.qti_threshold;
	assign r_blk = item.right_level > cfg.qti_threshold;
	assign rem_dec = (remaining_ms_q != '0) ? remaining_ms_q - 1'b1 : '0;

	always_comb begin
		timed_active_d = timed_active_q;
		remaining_ms_d = remaining_ms_q;
		held_left_d    = held_left_q;
		held_right_d   = held_right_q;
		off_track_d    = off_track_q;
		seen_d         = seen_q;
		res_valid      = 1'b0;
		lp             = stand;
		rp             = stand;
		ev             = EV_NONE;
		case (item.command)
			CMD_SAMPLE: begin
				if (!timed_active_q) begin
					res_valid = 1'b1;
					if (!l_blk && !c_blk && !r_blk) begin
						ev          = off_track_q ? EV_NONE : EV_TRACK_LOST;
						off_track_d = 1'b1;
					end else begin
						off_track_d = 1'b0;
						if (l_blk && c_blk && r_blk) begin
							seen_d = 1'b1;
							ev     = EV_CROSSING;
						end else if (!l_blk && c_blk && !r_blk) begin
							lp = stand + speed;
							rp = stand - speed;
						end else if (l_blk) begin
							lp = stand - half;
							rp = stand - speed;
						end else begin
							lp = stand + speed;
							rp = stand + half;
						end
					end
				end
			end
			CMD_MOVE: begin
				held_left_d    = item.move_left_pulse;
				held_right_d   = item.move_right_pulse;
				remaining_ms_d = item.duration_ms;
				timed_active_d = 1'b1;
				res_valid      = 1'b1;
				lp             = item.move_left_pulse;
				rp             = item.move_right_pulse;
			end
			CMD_TICK: begin
				if (timed_active_q) begin
					res_valid      = 1'b1;
					remaining_ms_d = rem_dec;
					if (rem_dec == '0) begin
						timed_active_d = 1'b0;
					end else begin
						lp = held_left_q;
						rp = held_right_q;
					end
				end
			end
			CMD_STOP: begin
				timed_active_d = 1'b0;
				res_valid      = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.left_pulse        = clamp(lp, lo, hi);
		res.right_pulse       = clamp(rp, lo, hi);
		res.event_code        = ev;
		res.move_busy         = timed_active_d;
		res.intersection_seen = seen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timed_active_q <= 1'b0;
			remaining_ms_q <= '0;
			held_left_q    <= MOVE_W'(STANDSTILL_US);
			held_right_q   <= MOVE_W'(STANDSTILL_US);
			off_track_q    <= 1'b0;
			seen_q         <= 1'b0;
		end else if (fire) begin
			timed_active_q <= timed_active_d;
			remaining_ms_q <= remaining_ms_d;
			held_left_q    <= held_left_d;
			held_right_q   <= held_right_d;
			off_track_q    <= off_track_d;
			seen_q         <= seen_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/line_follower_servo_steering.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An item is held in the input register, steered combinationally by the core and
// the result is held in the output register; commands with no result leave no gap.
// Throughput: one item per cycle unless the output register holds an untaken result.
// The input register is released as soon as the output register is free or drained.
// Reset is asynchronous and active low: it empties both registers, clears the
// steering state and loads the default threshold and speed.
module line_follower_servo_steering #(
	parameter int unsigned STANDSTILL_US = 1500,
	parameter int unsigned DEFAULT_SPEED = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// left_level[9:0], middle_level[19:10], right_level[29:20],
	// move_left_pulse[41:30], move_right_pulse[53:42], duration_ms[69:54], zero pad
	input  wire logic [71:0] s_tdata,
	// command[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// left_pulse[10:0], right_pulse[21:11], move_busy[22], intersection_seen[23]
	output logic      [23:0] m_tdata,
	// event_code[1:0]
	output logic      [1:0]  m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import lfss_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	logic  res_valid;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	lfss_cfg #(
		.DEFAULT_SPEED(DEFAULT_SPEED)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command          <= cmd_t'(s_tuser);
			item_s1.left_level       <= s_tdata[9:0];
			item_s1.middle_level     <= s_tdata[19:10];
			item_s1.right_level      <= s_tdata[29:20];
			item_s1.move_left_pulse  <= s_tdata[41:30];
			item_s1.move_right_pulse <= s_tdata[53:42];
			item_s1.duration_ms      <= s_tdata[69:54];
		end
	end

	lfss_core #(
		.STANDSTILL_US(STANDSTILL_US)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.cfg      (cfg),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.intersection_seen, res_s2.move_busy,
		res_s2.right_pulse, res_s2.left_pulse};
	assign m_tuser  = res_s2.event_code;

`ifndef NO_ASSERTIONS
	logic [MOVE_W-1:0] chk_lo;
	logic [MOVE_W-1:0] chk_hi;

	assign chk_lo = MOVE_W'(STANDSTILL_US) - {{(MOVE_W-SPEED_W){1'b0}}, cfg.max_speed};
	assign chk_hi = MOVE_W'(STANDSTILL_US) + {{(MOVE_W-SPEED_W){1'b0}}, cfg.max_speed};

	a_event_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != EV_NONE) |-> !m_tdata[22])
		else $error("event reported while a timed move is running");

	a_intersection_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_CROSSING) |-> m_tdata[23])
		else $error("intersection event without the sticky flag");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid) |->
		({1'b0, res.left_pulse} >= chk_lo && {1'b0, res.left_pulse} <= chk_hi &&
		 {1'b0, res.right_pulse} >= chk_lo && {1'b0, res.right_pulse} <= chk_hi))
		else $error("pulse outside the speed window");
`endif

endmodule

`default_nettype wire
